// ----- src/bgd_pkg.sv -----
`default_nettype none

package bgd_pkg;

  // Feature fields carried by one input word
  localparam int FEAT_INPUTS = 8;
  localparam int MAX_FEATURES_DEF = 8;

  localparam int DATA_W = 32;
  localparam int PROD_W = 48;
  localparam int SUM_W = 48;
  localparam int IN_TDATA_W = DATA_W * (FEAT_INPUTS + 1);
  localparam int OUT_TDATA_W = 40;
  localparam int IDX_W = 3;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REG_STEP_SCALE = 2'd0;
  localparam logic [1:0] REG_ACTIVE_FEATURES = 2'd1;
  localparam logic [1:0] REG_MAX_PASSES = 2'd2;

  localparam logic [23:0] STEP_SCALE_RST = 24'd167772;
  localparam logic [3:0] ACTIVE_FEATURES_RST = 4'd8;
  localparam logic [15:0] MAX_PASSES_RST = 16'd1;

  typedef struct packed {
    logic [23:0] step_scale;
    logic [3:0]  active_features;
    logic [15:0] max_passes;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic mul_en;
    logic sel_se;
    logic acc_en;
    logic upd_en;
  } lane_ctrl_t;

  typedef struct packed {
    logic sum_en;
    logic err_en;
    logic scale_en;
  } merge_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_ERR,
    ST_SCALE,
    ST_TERM,
    ST_ACC,
    ST_UPD,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

// ----- src/bgd_lane.sv -----
`default_nettype none

module bgd_lane (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire bgd_pkg::lane_ctrl_t  ctrl,
  input  wire                       active,
  input  wire logic signed [31:0]   x_in,
  input  wire logic signed [31:0]   se_in,
  output logic signed [47:0]        prod,
  output logic signed [31:0]        weight
);

  logic signed [31:0] x_r;
  logic signed [31:0] w_r;
  logic signed [47:0] sum_r;
  logic signed [47:0] prod_r;

  logic signed [31:0] mul_b;
  logic signed [63:0] mul_full;
  logic signed [48:0] acc_wide;
  logic signed [47:0] acc_sat;
  logic signed [48:0] upd_wide;
  logic signed [31:0] upd_sat;

  // One multiplier: x*w for the dot product, then x*se for the update term
  assign mul_b = ctrl.sel_se ? se_in : w_r;
  assign mul_full = x_r * mul_b;

  assign acc_wide = {sum_r[47], sum_r} + {prod_r[47], prod_r};
  always_comb begin
    if (acc_wide[48] == acc_wide[47]) begin
      acc_sat = acc_wide[47:0];
    end else if (acc_wide[48]) begin
      acc_sat = {1'b1, 47'd0};
    end else begin
      acc_sat = {1'b0, {47{1'b1}}};
    end
  end

  assign upd_wide = {{17{w_r[31]}}, w_r} - {sum_r[47], sum_r};
  always_comb begin
    if (&upd_wide[48:31] || ~|upd_wide[48:31]) begin
      upd_sat = upd_wide[31:0];
    end else if (upd_wide[48]) begin
      upd_sat = 32'h8000_0000;
    end else begin
      upd_sat = 32'h7fff_ffff;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x_r <= x_in;
    end
    if (ctrl.mul_en) begin
      prod_r <= mul_full[63:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r   <= '0;
      sum_r <= '0;
    end else begin
      if (ctrl.acc_en && active) begin
        sum_r <= acc_sat;
      end
      // Clear every sum at pass end, active or not
      if (ctrl.upd_en) begin
        sum_r <= '0;
        if (active) begin
          w_r <= upd_sat;
        end
      end
    end
  end

  assign prod = prod_r;
  assign weight = w_r;

endmodule

`default_nettype wire

// ----- src/bgd_merge.sv -----
`default_nettype none

module bgd_merge #(
  parameter int NL = bgd_pkg::MAX_FEATURES_DEF
) (
  input  wire                        clk,
  input  wire bgd_pkg::merge_ctrl_t  ctrl,
  input  wire logic signed [47:0]    prod [NL],
  input  wire [NL-1:0]               active,
  input  wire logic signed [31:0]    target,
  input  wire [23:0]                 step_scale,
  output logic signed [31:0]         se
);

  localparam int DOT_W = bgd_pkg::PROD_W + $clog2(NL) + 1;

  logic signed [DOT_W-1:0] dot_sum;
  logic signed [DOT_W-1:0] dot_r;
  logic signed [31:0]      dot_sat;
  logic signed [32:0]      diff;
  logic signed [31:0]      e_nxt;
  logic signed [31:0]      e_r;
  logic signed [56:0]      scaled;
  logic signed [31:0]      se_r;

  always_comb begin
    dot_sum = '0;
    for (int i = 0; i < NL; i++) begin
      if (active[i]) begin
        dot_sum = dot_sum + {{(DOT_W - bgd_pkg::PROD_W){prod[i][47]}}, prod[i]};
      end
    end
  end

  always_comb begin
    if (&dot_r[DOT_W-1:31] || ~|dot_r[DOT_W-1:31]) begin
      dot_sat = dot_r[31:0];
    end else if (dot_r[DOT_W-1]) begin
      dot_sat = 32'h8000_0000;
    end else begin
      dot_sat = 32'h7fff_ffff;
    end
  end

  assign diff = {dot_sat[31], dot_sat} - {target[31], target};
  always_comb begin
    if (diff[32] == diff[31]) begin
      e_nxt = diff[31:0];
    end else if (diff[32]) begin
      e_nxt = 32'h8000_0000;
    end else begin
      e_nxt = 32'h7fff_ffff;
    end
  end

  // Q0.24 scale; the result never exceeds the error in magnitude
  assign scaled = $signed({1'b0, step_scale}) * e_r;

  always_ff @(posedge clk) begin
    if (ctrl.sum_en) begin
      dot_r <= dot_sum;
    end
    if (ctrl.err_en) begin
      e_r <= e_nxt;
    end
    if (ctrl.scale_en) begin
      se_r <= scaled[55:24];
    end
  end

  assign se = se_r;

endmodule

`default_nettype wire

// ----- src/bgd_regs.sv -----
`default_nettype none

module bgd_regs (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire [bgd_pkg::CFG_ADDR_W-1:0]        paddr,
  input  wire [bgd_pkg::CFG_DATA_W-1:0]        pwdata,
  output logic [bgd_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                 pready,
  output bgd_pkg::cfg_t                        cfg
);

  bgd_pkg::cfg_t cfg_r;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_scale      <= bgd_pkg::STEP_SCALE_RST;
      cfg_r.active_features <= bgd_pkg::ACTIVE_FEATURES_RST;
      cfg_r.max_passes      <= bgd_pkg::MAX_PASSES_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        bgd_pkg::REG_STEP_SCALE:      cfg_r.step_scale <= pwdata[23:0];
        bgd_pkg::REG_ACTIVE_FEATURES: cfg_r.active_features <= pwdata[3:0];
        bgd_pkg::REG_MAX_PASSES:      cfg_r.max_passes <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      bgd_pkg::REG_STEP_SCALE:      prdata = {8'd0, cfg_r.step_scale};
      bgd_pkg::REG_ACTIVE_FEATURES: prdata = {28'd0, cfg_r.active_features};
      bgd_pkg::REG_MAX_PASSES:      prdata = {16'd0, cfg_r.max_passes};
      default:                      prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- src/batch_gradient_descent_linreg.sv -----
`default_nettype none

// Channel  Dir  Ports                        Contents
// in       in   in_tvalid/tready/tdata/tlast record: target, feature_0..7; tlast = last of pass
// out      out  out_tvalid/tready/tdata/     weight_index, weight_value; tlast = last weight;
//                out_tlast/tuser              tuser = training done
// cfg      in   cfg_p* (APB)                 step_scale @0x0, active_features @0x4,
//                                             max_passes @0x8
//
// A record passes through accept, lane multiply x*w, merge sum, error, step scale,
// lane multiply x*se and accumulate. The shared multiplier in each lane sets this chain.
// A record ending a pass adds a weight update step and then emits one weight per cycle
// while out_tready is high. Records arriving after training is done are taken and dropped.
// Synchronous reset clears weights, sums, pass count and registers. The output register
// lets the last weight wait while the next record starts.

module batch_gradient_descent_linreg #(
  parameter int MAX_FEATURES = bgd_pkg::MAX_FEATURES_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  // target [31:0], feature_0 [63:32] ... feature_7 [287:256]
  input  wire [bgd_pkg::IN_TDATA_W-1:0]        in_tdata,
  input  wire                                  in_tlast,
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  // weight_index [2:0], weight_value [34:3], zero [39:35]
  output logic [bgd_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                 out_tlast,
  // training_done [0]
  output logic                                 out_tuser,
  input  wire                                  cfg_psel,
  input  wire                                  cfg_penable,
  input  wire                                  cfg_pwrite,
  input  wire [bgd_pkg::CFG_ADDR_W-1:0]        cfg_paddr,
  input  wire [bgd_pkg::CFG_DATA_W-1:0]        cfg_pwdata,
  output logic [bgd_pkg::CFG_DATA_W-1:0]       cfg_prdata,
  output logic                                 cfg_pready
);

  localparam int NL = MAX_FEATURES;
  localparam int CAP = (NL < bgd_pkg::FEAT_INPUTS) ? NL : bgd_pkg::FEAT_INPUTS;

  bgd_pkg::cfg_t        cfg;
  bgd_pkg::state_t      state_r, state_nxt;
  bgd_pkg::lane_ctrl_t  lctl;
  bgd_pkg::merge_ctrl_t mctl;

  logic signed [31:0] lane_w [NL];
  logic signed [47:0] lane_prod [NL];
  logic [NL-1:0]      lane_active;
  logic signed [31:0] se;

  logic signed [31:0]            y_r;
  logic                          last_r;
  logic [15:0]                   pass_r;
  logic [bgd_pkg::IDX_W-1:0]     idx_r, idx_nxt;
  logic [3:0]                    n_eff;
  logic                          finished;
  logic                          accept;
  logic                          is_last;
  logic signed [31:0]            sel_w;

  logic                          out_valid_r, out_valid_nxt;
  logic                          out_load;
  logic [bgd_pkg::IDX_W-1:0]     out_idx_r;
  logic signed [31:0]            out_val_r;
  logic                          out_last_r;
  logic                          out_done_r;

  bgd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Clamp feature count to 1..CAP
  always_comb begin
    if (cfg.active_features == 4'd0) begin
      n_eff = 4'd1;
    end else if (cfg.active_features > 4'(CAP)) begin
      n_eff = 4'(CAP);
    end else begin
      n_eff = cfg.active_features;
    end
  end

  assign finished = (pass_r >= cfg.max_passes);
  assign accept = in_tvalid & in_tready;

  for (genvar g = 0; g < NL; g++) begin : g_lane
    logic signed [31:0] x_in;
    if (g < CAP) begin : g_act
      assign lane_active[g] = (n_eff > 4'(g));
      assign x_in = in_tdata[bgd_pkg::DATA_W*(g+1) +: bgd_pkg::DATA_W];
    end else begin : g_idle
      assign lane_active[g] = 1'b0;
      assign x_in = '0;
    end

    bgd_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (lctl),
      .active (lane_active[g]),
      .x_in   (x_in),
      .se_in  (se),
      .prod   (lane_prod[g]),
      .weight (lane_w[g])
    );
  end

  bgd_merge #(
    .NL (NL)
  ) u_merge (
    .clk        (clk),
    .ctrl       (mctl),
    .prod       (lane_prod),
    .active     (lane_active),
    .target     (y_r),
    .step_scale (cfg.step_scale),
    .se         (se)
  );

  always_comb begin
    sel_w = '0;
    for (int i = 0; i < CAP; i++) begin
      if (idx_r == 3'(i)) begin
        sel_w = lane_w[i];
      end
    end
  end

  assign is_last = ({1'b0, idx_r} == (n_eff - 4'd1));

  always_comb begin
    state_nxt     = state_r;
    lctl          = '0;
    mctl          = '0;
    idx_nxt       = idx_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r & ~out_tready;
    in_tready     = 1'b0;
    unique case (state_r)
      bgd_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        // drop records once training is done
        if (accept && !finished) begin
          lctl.load = 1'b1;
          state_nxt = bgd_pkg::ST_MUL;
        end
      end
      bgd_pkg::ST_MUL: begin
        lctl.mul_en = 1'b1;
        state_nxt   = bgd_pkg::ST_SUM;
      end
      bgd_pkg::ST_SUM: begin
        mctl.sum_en = 1'b1;
        state_nxt   = bgd_pkg::ST_ERR;
      end
      bgd_pkg::ST_ERR: begin
        mctl.err_en = 1'b1;
        state_nxt   = bgd_pkg::ST_SCALE;
      end
      bgd_pkg::ST_SCALE: begin
        mctl.scale_en = 1'b1;
        state_nxt     = bgd_pkg::ST_TERM;
      end
      bgd_pkg::ST_TERM: begin
        lctl.mul_en = 1'b1;
        lctl.sel_se = 1'b1;
        state_nxt   = bgd_pkg::ST_ACC;
      end
      bgd_pkg::ST_ACC: begin
        lctl.acc_en = 1'b1;
        state_nxt   = last_r ? bgd_pkg::ST_UPD : bgd_pkg::ST_IDLE;
      end
      bgd_pkg::ST_UPD: begin
        lctl.upd_en = 1'b1;
        idx_nxt     = '0;
        state_nxt   = bgd_pkg::ST_EMIT;
      end
      bgd_pkg::ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          idx_nxt       = idx_r + 3'd1;
          if (is_last) begin
            state_nxt = bgd_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = bgd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bgd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      pass_r      <= '0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      // saturate the pass count
      if (lctl.upd_en && pass_r != 16'hffff) begin
        pass_r <= pass_r + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lctl.load) begin
      y_r    <= in_tdata[bgd_pkg::DATA_W-1:0];
      last_r <= in_tlast;
    end
    if (out_load) begin
      out_idx_r  <= idx_r;
      out_val_r  <= sel_w;
      out_last_r <= is_last;
      out_done_r <= finished;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_val_r, out_idx_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_done_r;

endmodule

`default_nettype wire
